// ----- rtl/amt_pkg.sv -----
// ----------------------------------------------------------------------------
// amt_pkg: shared types and codes for the active member timeout table
// Entry layout, controller states, result status codes and cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package amt_pkg;

    localparam int AMT_TABLE_ENTRIES = 32;

    localparam int GROUP_W  = 16;
    localparam int MEMBER_W = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LISTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic [GROUP_W-1:0]  group_id;
        logic [MEMBER_W-1:0] member_id;
        logic [TIME_W-1:0]   stamp;
    } t_entry;

    // Controls common to every cell of the chain
    typedef struct packed {
        logic shift;
        logic load_en;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } t_state;

endpackage : amt_pkg

`default_nettype wire

// ----- rtl/active_member_timeout_table.sv -----
// Sequence: each stored entry is popped from the chain head, checked and
// re-appended at the tail if still live, then the finish state emits the last
// word. The input is stalled until that word is sent, so a new item waits.
// A query lists one member per cycle while the output is not stalled.
// A stalled output holds the sweep only when a further member must be listed.
// Reset: synchronous, active low; empties the table, clears timeout to 0.
// ----------------------------------------------------------------------------
// active_member_timeout_table: group/member table with timeout aging
// Reports refresh a (group, member) entry at the newest end; queries list a
// group's live members oldest first. Expired entries are dropped on each item.
// ----------------------------------------------------------------------------
`default_nettype none

module active_member_timeout_table #(
    parameter int TABLE_ENTRIES = amt_pkg::AMT_TABLE_ENTRIES
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire [amt_pkg::TIME_W-1:0]     i_cfg_wr_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_mode,
    input  wire [amt_pkg::GROUP_W-1:0]    i_group_id,
    input  wire [amt_pkg::MEMBER_W-1:0]   i_member_id,
    input  wire [amt_pkg::TIME_W-1:0]     i_time_now,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [amt_pkg::STATUS_W-1:0]  o_status,
    output logic [amt_pkg::MEMBER_W-1:0]  o_listed_member,
    output logic                          o_last
);
    import amt_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_state               r_state, n_state;
    logic                 r_mode;
    logic [GROUP_W-1:0]   r_group;
    logic [MEMBER_W-1:0]  r_member;
    logic [TIME_W-1:0]    r_time;
    logic [TIME_W-1:0]    r_window;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_left;
    logic                 r_pend_valid;
    logic [MEMBER_W-1:0]  r_pend_member;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [MEMBER_W-1:0]  r_out_member;
    logic                 r_out_last;

    t_entry               w_head;
    t_entry               w_new_entry;
    t_chain_ctl           w_ctl;
    logic [CW-1:0]        w_load_pos;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_live;
    logic                 w_keep;
    logic                 w_match;
    logic                 w_full;
    logic                 w_step;
    logic                 w_emit;
    logic [STATUS_W-1:0]  w_emit_status;
    logic [MEMBER_W-1:0]  w_emit_member;
    logic                 w_emit_last;
    logic                 w_append;

    // hold off input words while busy or in reset
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Entries stamped after now have age zero and stay live
    assign w_live  = (r_time < w_head.stamp) || ((r_time - w_head.stamp) <= r_window);
    assign w_keep  = w_live && !((r_mode == MODE_REPORT) && (w_head.group_id == r_group)
                                 && (w_head.member_id == r_member));
    assign w_match = w_keep && (r_mode == MODE_QUERY) && (w_head.group_id == r_group);
    assign w_full  = (r_count == CW'(TABLE_ENTRIES));

    assign w_new_entry.group_id  = r_group;
    assign w_new_entry.member_id = r_member;
    assign w_new_entry.stamp     = r_time;

    amt_chain #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_load_pos   (w_load_pos),
        .i_load_entry (r_mode == MODE_QUERY ? w_head : (w_step ? w_head : w_new_entry)),
        .o_head       (w_head)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_left == '0) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb begin
        w_ctl         = '0;
        w_load_pos    = '0;
        w_step        = 1'b0;
        w_emit        = 1'b0;
        w_emit_status = ST_STORED;
        w_emit_member = '0;
        w_emit_last   = 1'b0;
        w_append      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_SWEEP: begin
                // hold the sweep while a listed member cannot leave
                if ((r_left != '0) && !(w_match && r_pend_valid && !w_out_free)) begin
                    w_step        = 1'b1;
                    w_ctl.shift   = 1'b1;
                    w_ctl.load_en = w_keep;
                    w_load_pos    = r_count - CW'(1);
                    if (w_match && r_pend_valid) begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_LISTED;
                        w_emit_member = r_pend_member;
                    end
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                    if (r_mode == MODE_REPORT) begin
                        if (w_full) begin
                            w_emit_status = ST_FULL;
                        end else begin
                            w_append      = 1'b1;
                            w_ctl.load_en = 1'b1;
                            w_load_pos    = r_count;
                        end
                    end else if (r_pend_valid) begin
                        w_emit_status = ST_LISTED;
                        w_emit_member = r_pend_member;
                    end else begin
                        w_emit_status = ST_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= '0;
            r_count      <= '0;
            r_left       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_window <= i_cfg_wr_data;
            if (w_accept) begin
                r_left       <= r_count;
                r_pend_valid <= 1'b0;
            end
            if (w_step) begin
                r_left <= r_left - CW'(1);
                if (!w_keep) r_count <= r_count - CW'(1);
                if (w_match) r_pend_valid <= 1'b1;
            end
            if (w_append) r_count <= r_count + CW'(1);
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_group  <= i_group_id;
            r_member <= i_member_id;
            r_time   <= i_time_now;
        end
        if (w_step && w_match) r_pend_member <= w_head.member_id;
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_member <= w_emit_member;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_listed_member = r_out_member;
    assign o_last          = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_left <= r_count))
        else $error("sweep counter exceeds entry count");

    a_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SWEEP))
        else $error("accepted word did not start a sweep");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_LISTED)) |-> o_last)
        else $error("single result word without last");

    a_emit_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=> (o_out_valid && o_last))
        else $error("finish did not deliver the last word");

endmodule : active_member_timeout_table

`default_nettype wire

// ----- rtl/amt_cell.sv -----
// ----------------------------------------------------------------------------
// amt_cell: one slot of the entry chain
// Holds one entry; takes its upper neighbor's entry on a shift, or a new
// entry when selected for load.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_cell (
    input  wire                      i_clk,
    input  wire amt_pkg::t_chain_ctl i_ctl,
    input  wire                      i_sel,
    input  wire amt_pkg::t_entry     i_load_entry,
    input  wire amt_pkg::t_entry     i_next_entry,
    output amt_pkg::t_entry          o_entry
);
    import amt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load_en && i_sel) begin
            n_entry = i_load_entry;
        end else if (i_ctl.shift) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule : amt_cell

`default_nettype wire

// ----- rtl/amt_chain.sv -----
// ----------------------------------------------------------------------------
// amt_chain: row of entry cells, oldest entry at cell zero
// A shift moves every entry one cell toward the head; one cell may load.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_chain #(
    parameter int TABLE_ENTRIES = amt_pkg::AMT_TABLE_ENTRIES,
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire                      i_clk,
    input  wire amt_pkg::t_chain_ctl i_ctl,
    input  wire [CW-1:0]             i_load_pos,
    input  wire amt_pkg::t_entry     i_load_entry,
    output amt_pkg::t_entry          o_head
);
    import amt_pkg::*;

    t_entry w_data [TABLE_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            t_entry w_next;
            if (gi == TABLE_ENTRIES - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_body
                assign w_next = w_data[gi+1];
            end
            amt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (i_ctl),
                .i_sel        (i_load_pos == CW'(gi)),
                .i_load_entry (i_load_entry),
                .i_next_entry (w_next),
                .o_entry      (w_data[gi])
            );
        end
    endgenerate

    assign o_head = w_data[0];

endmodule : amt_chain

`default_nettype wire
